// ===== rtl/spi_nine_bit_word_packer_macros.svh =====
// assertion helpers shared by the packer rtl
`ifndef SPI_NINE_BIT_WORD_PACKER_MACROS_SVH
`define SPI_NINE_BIT_WORD_PACKER_MACROS_SVH

// same-cycle implication, checked out of reset
`define SNWP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SNWP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/snwp_pkg.sv =====
package snwp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned ResW   = 7;
  localparam int unsigned ResCntW = 3;

  // output word queue
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoIdxW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_SEND  = 2'd1,
    FUNC_END   = 2'd2
  } func_e;

  typedef struct packed {
    logic [1:0]       func;
    logic [ByteW-1:0] data_byte;
    logic             dc;
  } in_word_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             last;
    logic             transfer_end;
  } out_word_t;

endpackage

// ===== rtl/snwp_stream_if.sv =====
interface snwp_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/spi_nine_bit_word_packer.sv =====
// Packs 9-bit display words (dc bit, then data byte) into an MSB-first byte
// stream for a 3-wire SPI shifter. A start word clears the pending bits, a
// send word adds nine bits and puts out every byte that is now complete (one,
// or two when seven bits were pending), an end word puts out any pending bits
// zero-padded on the right as one byte flagged transfer_end. last marks the
// final byte caused by an input word. Each input word is handled in the cycle
// it is taken: the packing logic sits between the pending-bit register and a
// four-entry output queue, into which its result bytes are registered. The
// input takes one word per cycle while the queue has room for two bytes; the
// output port drains one byte per cycle while out_o.ready is high, and a long
// run of send words gives nine output bytes per eight words.
`include "spi_nine_bit_word_packer_macros.svh"

module spi_nine_bit_word_packer
  import snwp_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  snwp_stream_if.sink   in_i,
  snwp_stream_if.source out_o
);

  // pending bits, right-aligned, and how many of them are valid
  logic [ResW-1:0]    res_bits_q, res_bits_d;
  logic [ResCntW-1:0] res_cnt_q, res_cnt_d;

  // output queue
  out_word_t         fifo_q [FifoDepth];
  logic [FifoIdxW-1:0] wptr_q, rptr_q;
  logic [FifoCntW-1:0] fcnt_q, fcnt_d;

  in_word_t   in_word;
  logic       in_acc;
  logic       out_pop;
  logic [1:0] push_n;
  out_word_t  ent0, ent1;

  // packing datapath
  logic [ResW-1:0]  res_mask;
  logic [ResW-1:0]  res_live;
  logic [15:0]      acc;
  logic [3:0]       rem;
  logic [15:0]      acc_sh;
  logic [ByteW-1:0] keep_mask;
  logic [ByteW-1:0] flush_byte;

  assign in_word = in_i.payload;

  // room for the worst case of two bytes per word
  assign in_i.ready = (fcnt_q <= FifoCntW'(FifoDepth - 2));
  assign in_acc     = in_i.valid && in_i.ready;

  assign out_o.valid   = (fcnt_q != '0);
  assign out_o.payload = fifo_q[rptr_q];
  assign out_pop       = out_o.valid && out_o.ready;

  always_comb begin
    // only the low res_cnt_q bits count
    res_mask   = ResW'((8'd1 << res_cnt_q) - 8'd1);
    res_live   = res_bits_q & res_mask;
    // pending bits followed by the new nine-bit word
    acc        = {res_live, in_word.dc, in_word.data_byte};
    rem        = 4'({1'b0, res_cnt_q}) + 4'd1;
    acc_sh     = acc >> rem;
    keep_mask  = ByteW'((9'd1 << rem[2:0]) - 9'd1);
    flush_byte = ByteW'({1'b0, res_live} << (4'd8 - {1'b0, res_cnt_q}));

    res_bits_d = res_bits_q;
    res_cnt_d  = res_cnt_q;
    push_n     = 2'd0;
    ent0       = '{out_byte: acc_sh[ByteW-1:0], last: 1'b1, transfer_end: 1'b0};
    ent1       = '{out_byte: acc[ByteW-1:0],    last: 1'b1, transfer_end: 1'b0};

    if (in_acc) begin
      unique case (in_word.func)
        FUNC_START: begin
          res_bits_d = '0;
          res_cnt_d  = '0;
        end
        FUNC_SEND: begin
          if (rem == 4'd8) begin
            // seven pending bits plus nine new ones make two whole bytes
            ent0.last  = 1'b0;
            push_n     = 2'd2;
            res_bits_d = '0;
            res_cnt_d  = '0;
          end else begin
            push_n     = 2'd1;
            res_bits_d = acc[ResW-1:0] & keep_mask[ResW-1:0];
            res_cnt_d  = rem[ResCntW-1:0];
          end
        end
        FUNC_END: begin
          // nothing pending means nothing to flush
          if (res_cnt_q != '0) begin
            ent0   = '{out_byte: flush_byte, last: 1'b1, transfer_end: 1'b1};
            push_n = 2'd1;
          end
          res_bits_d = '0;
          res_cnt_d  = '0;
        end
        default: begin
          // unused code, ignored
        end
      endcase
    end

    fcnt_d = fcnt_q + FifoCntW'(push_n) - FifoCntW'(out_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_bits_q <= '0;
      res_cnt_q  <= '0;
      wptr_q     <= '0;
      rptr_q     <= '0;
      fcnt_q     <= '0;
    end else begin
      res_bits_q <= res_bits_d;
      res_cnt_q  <= res_cnt_d;
      wptr_q     <= wptr_q + FifoIdxW'(push_n);
      rptr_q     <= rptr_q + FifoIdxW'(out_pop);
      fcnt_q     <= fcnt_d;
    end
  end

  // queue storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      fifo_q[wptr_q] <= ent0;
    end
    if (push_n == 2'd2) begin
      fifo_q[wptr_q + FifoIdxW'(1)] <= ent1;
    end
  end

  `SNWP_ASSERT_IMP(a_res_clean, 1'b1, (res_bits_q & ~res_mask) == '0,
    "pending bits above the count are not clear")
  `SNWP_ASSERT_IMP(a_pair_queued, out_o.valid && !out_o.payload.last, fcnt_q >= FifoCntW'(2),
    "non-last byte at queue head without its partner")
  `SNWP_ASSERT_NXT(a_clear_after, in_acc && (in_word.func == FUNC_START ||
    in_word.func == FUNC_END), res_cnt_q == '0,
    "pending bits left after start or end")
  `SNWP_ASSERT_NXT(a_two_bytes, in_acc && in_word.func == FUNC_SEND &&
    res_cnt_q == ResCntW'(7), fcnt_q == $past(fcnt_q) + FifoCntW'(2) - FifoCntW'($past(out_pop)),
    "send with seven pending bits did not queue two bytes")
  `SNWP_ASSERT_IMP(a_no_overflow, 1'b1, fcnt_q <= FifoCntW'(FifoDepth),
    "output queue overflow")

endmodule
